/* rtl/lmp_pkg.sv */
// Shared types, constants and tables of the Legendre monomial product core.
package lmp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SAMPLE_W  = 18;
    localparam int COEF_W    = 18;
    localparam int ACC_W     = 36;
    localparam int MUL_W     = ACC_W + SAMPLE_W;
    localparam int MAX_VARS  = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int DEG_W     = 4;
    localparam int MAX_DEG   = 10;
    localparam int TERM_W    = 3;
    localparam int SHIFT_W   = 4;
    localparam int STEP_W    = 4;
    localparam int CFG_W     = 64;

    localparam logic signed [SAMPLE_W-1:0] ONE_Q = 18'sd65536;

    // Microprogram addresses that are jump targets
    localparam logic [STEP_W-1:0] UA_FETCH = 4'd0;
    localparam logic [STEP_W-1:0] UA_LOOP  = 4'd3;
    localparam logic [STEP_W-1:0] UA_ODD   = 4'd5;
    localparam logic [STEP_W-1:0] UA_LEG   = 4'd7;

    typedef enum logic {
        REG_VAR_COUNT   = 1'b0,
        REG_DEGREE_WORD = 1'b1
    } t_reg_idx;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        M_NONE,
        M_X_X,
        M_ACC_Y,
        M_ACC_X,
        M_PROD_LEG
    } t_msel;

    // Register writeback operations
    typedef enum logic [2:0] {
        WB_NONE,
        WB_LOAD,
        WB_Y,
        WB_HORNER,
        WB_ACC,
        WB_LEG,
        WB_PROD
    } t_wb;

    // Sequencing conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_WAIT_IN,
        C_TERMS_DONE,
        C_EVEN,
        C_WAIT_OUT
    } t_cond;

    typedef struct packed {
        t_msel             msel;
        t_wb               wb;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_msel msel;
        t_wb   wb;
        logic  row_end;
    } t_dp_ctrl;

    typedef struct packed {
        logic terms_done;
        logic deg_odd;
    } t_dp_stat;

    // Control store: one word per step
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            4'd0:    w = '{M_NONE,     WB_LOAD,   C_WAIT_IN,    UA_FETCH};
            4'd1:    w = '{M_X_X,      WB_NONE,   C_NEXT,       UA_FETCH};
            4'd2:    w = '{M_NONE,     WB_Y,      C_NEXT,       UA_FETCH};
            4'd3:    w = '{M_ACC_Y,    WB_NONE,   C_TERMS_DONE, UA_ODD};
            4'd4:    w = '{M_NONE,     WB_HORNER, C_JUMP,       UA_LOOP};
            4'd5:    w = '{M_ACC_X,    WB_NONE,   C_EVEN,       UA_LEG};
            4'd6:    w = '{M_NONE,     WB_ACC,    C_NEXT,       UA_FETCH};
            4'd7:    w = '{M_NONE,     WB_LEG,    C_NEXT,       UA_FETCH};
            4'd8:    w = '{M_PROD_LEG, WB_NONE,   C_NEXT,       UA_FETCH};
            4'd9:    w = '{M_NONE,     WB_PROD,   C_WAIT_OUT,   UA_FETCH};
            default: w = '{M_NONE,     WB_NONE,   C_JUMP,       UA_FETCH};
        endcase
        return w;
    endfunction

    // Numerators in powers of x squared, highest power first
    function automatic logic signed [COEF_W-1:0] leg_coef(
        input logic [DEG_W-1:0]  deg,
        input logic [TERM_W-1:0] term
    );
        logic signed [COEF_W-1:0] row [6];
        unique case (deg)
            4'd0, 4'd1: row = '{1, 0, 0, 0, 0, 0};
            4'd2:  row = '{3, -1, 0, 0, 0, 0};
            4'd3:  row = '{5, -3, 0, 0, 0, 0};
            4'd4:  row = '{35, -30, 3, 0, 0, 0};
            4'd5:  row = '{63, -70, 15, 0, 0, 0};
            4'd6:  row = '{231, -315, 105, -5, 0, 0};
            4'd7:  row = '{429, -693, 315, -35, 0, 0};
            4'd8:  row = '{6435, -12012, 6930, -1260, 35, 0};
            4'd9:  row = '{12155, -25740, 18018, -4620, 315, 0};
            4'd10: row = '{46189, -109395, 90090, -30030, 3465, -63};
            default: row = '{0, 0, 0, 0, 0, 0};
        endcase
        return (term < 3'd6) ? row[term] : '0;
    endfunction

    function automatic logic [TERM_W-1:0] leg_terms(input logic [DEG_W-1:0] deg);
        logic [TERM_W-1:0] t;
        unique case (deg)
            4'd0, 4'd1:  t = 3'd1;
            4'd2, 4'd3:  t = 3'd2;
            4'd4, 4'd5:  t = 3'd3;
            4'd6, 4'd7:  t = 3'd4;
            4'd8, 4'd9:  t = 3'd5;
            4'd10:       t = 3'd6;
            default:     t = 3'd1;
        endcase
        return t;
    endfunction

    function automatic logic [SHIFT_W-1:0] leg_shift(input logic [DEG_W-1:0] deg);
        logic [SHIFT_W-1:0] s;
        unique case (deg)
            4'd0, 4'd1:  s = 4'd0;
            4'd2, 4'd3:  s = 4'd1;
            4'd4, 4'd5:  s = 4'd3;
            4'd6, 4'd7:  s = 4'd4;
            4'd8, 4'd9:  s = 4'd7;
            4'd10:       s = 4'd8;
            default:     s = 4'd0;
        endcase
        return s;
    endfunction

    // Saturate a wide value to [-1.0, 1.0]
    function automatic logic signed [SAMPLE_W-1:0] clamp_one(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] one_w;
        logic signed [SAMPLE_W-1:0] r;
        one_w = {{(ACC_W-SAMPLE_W){1'b0}}, ONE_Q};
        if (v > one_w) begin
            r = ONE_Q;
        end else if (v < -one_w) begin
            r = -ONE_Q;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/lmp_sample_if.sv */
// Input channel carrying one variable sample per transfer.
interface lmp_sample_if import lmp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/lmp_result_if.sv */
// Output channel carrying one row product per transfer.
interface lmp_result_if import lmp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] product;
    logic                       bad_degree;

    modport source (output valid, output product, output bad_degree, input ready);
    modport sink   (input valid, input product, input bad_degree, output ready);
endinterface

/* rtl/lmp_dp.sv */
// Arithmetic datapath: shared multiplier, Horner accumulator and row product.
module lmp_dp import lmp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_ctrl                   i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [DEG_W-1:0]           i_deg,
    output t_dp_stat                   o_stat,
    output logic signed [SAMPLE_W-1:0] o_prod_next
);

    localparam logic signed [MUL_W-1:0] HALF_P = MUL_W'(1) <<< (FRAC_BITS - 1);

    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_y;
    logic signed [SAMPLE_W-1:0] r_leg;
    logic signed [SAMPLE_W-1:0] r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [MUL_W-1:0]    r_p;
    logic [DEG_W-1:0]           r_deg;
    logic [TERM_W-1:0]          r_term;

    logic signed [ACC_W-1:0]    mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [MUL_W-1:0]    p_rnd_full;
    logic signed [ACC_W-1:0]    p_rnd;
    logic signed [COEF_W-1:0]   coef_load;
    logic signed [COEF_W-1:0]   coef_next;
    logic signed [ACC_W-1:0]    coef_load_q;
    logic signed [ACC_W-1:0]    coef_next_q;
    logic [SHIFT_W-1:0]         k;
    logic [ACC_W-1:0]           bias;
    logic signed [ACC_W-1:0]    acc_biased;
    logic signed [ACC_W-1:0]    acc_scaled;
    logic signed [SAMPLE_W-1:0] x_clamped;

    // Operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_ctrl.msel)
            M_X_X: begin
                mul_a = {{(ACC_W-SAMPLE_W){r_x[SAMPLE_W-1]}}, r_x};
                mul_b = r_x;
            end
            M_ACC_Y: begin
                mul_a = r_acc;
                mul_b = r_y;
            end
            M_ACC_X: begin
                mul_a = r_acc;
                mul_b = r_x;
            end
            M_PROD_LEG: begin
                mul_a = {{(ACC_W-SAMPLE_W){r_prod[SAMPLE_W-1]}}, r_prod};
                mul_b = r_leg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round half up back to the fixed-point scale
    assign p_rnd_full = (r_p + HALF_P) >>> FRAC_BITS;
    assign p_rnd      = p_rnd_full[ACC_W-1:0];

    assign coef_load   = leg_coef(i_deg, '0);
    assign coef_next   = leg_coef(r_deg, r_term);
    assign coef_load_q = {{(ACC_W-COEF_W-FRAC_BITS){coef_load[COEF_W-1]}},
                          coef_load, {FRAC_BITS{1'b0}}};
    assign coef_next_q = {{(ACC_W-COEF_W-FRAC_BITS){coef_next[COEF_W-1]}},
                          coef_next, {FRAC_BITS{1'b0}}};

    // Divide by the power-of-two denominator, rounding half up
    assign k          = leg_shift(r_deg);
    assign bias       = (ACC_W'(1) << k) >> 1;
    assign acc_biased = r_acc + $signed(bias);
    assign acc_scaled = acc_biased >>> k;

    assign x_clamped   = clamp_one({{(ACC_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample});
    assign o_prod_next = clamp_one(p_rnd);

    assign o_stat.terms_done = (r_term >= leg_terms(r_deg));
    assign o_stat.deg_odd    = r_deg[0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.msel != M_NONE) begin
            r_p <= mul_a * mul_b;
        end
        unique case (i_ctrl.wb)
            WB_LOAD: begin
                r_x    <= x_clamped;
                r_deg  <= i_deg;
                r_acc  <= coef_load_q;
                r_term <= TERM_W'(1);
            end
            WB_Y: begin
                r_y <= p_rnd[SAMPLE_W-1:0];
            end
            WB_HORNER: begin
                r_acc  <= p_rnd + coef_next_q;
                r_term <= r_term + TERM_W'(1);
            end
            WB_ACC: begin
                r_acc <= p_rnd;
            end
            WB_LEG: begin
                r_leg <= clamp_one(acc_scaled);
            end
            default: begin
            end
        endcase
    end

    // Running row product: back to one at reset and after each row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod <= ONE_Q;
        end else if (i_ctrl.wb == WB_PROD) begin
            r_prod <= i_ctrl.row_end ? ONE_Q : o_prod_next;
        end
    end

endmodule

/* rtl/legendre_monomial_product_core.sv */
// Top level of the Legendre monomial product core: sequencer, row control and ports.
//
// Usage: each transfer on i_sample brings one variable value in signed Q1.16
// (values beyond +-1.0 are clamped). Variable k of a row takes its Legendre
// degree from bits 4k+3..4k of the degree word; a slot above ten counts as
// degree zero and flags bad_degree on that row's result. After var_count
// variables (0 acts as 1, above 16 as 16) one transfer on o_result carries
// the saturated product of the row and the flag; other items give no result.
// Configuration: i_cfg_we writes i_cfg_data to the register chosen by
// i_cfg_idx (0: var_count, 1: degree_word); write only while idle.
// Sequencing: one item at a time under a ten-step microprogram driving one
// shared 36x18 multiplier. An item of degree d with T Horner terms loops
// over its terms, with one more multiply by x when d is odd; the shared
// multiplier is what bounds the item rate.
// A result is loaded into the output register as the last item of its row ends.
// Reset (synchronous, active low) returns the step counter to fetch, empties
// the output register, clears the row and loads the register defaults.
// Receiver stall: a finished result waits in the output register while the
// next row is worked; the last item of that row holds until the slot frees.
module legendre_monomial_product_core import lmp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lmp_sample_if.sink        i_sample,
    lmp_result_if.source      o_result,
    input  logic              i_cfg_we,
    input  t_reg_idx          i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    // Configuration registers
    logic [CNT_W-1:0]           r_var_count;
    logic [CFG_W-1:0]           r_degree_word;

    // Sequencer and row state
    logic [STEP_W-1:0]          r_step;
    logic [STEP_W-1:0]          n_step;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_err;

    // Output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_product;
    logic                       r_out_bad;

    t_uword                     uw;
    t_dp_ctrl                   dp_ctrl;
    t_dp_stat                   dp_stat;
    logic signed [SAMPLE_W-1:0] prod_next;
    logic [CNT_W-1:0]           count_eff;
    logic                       row_end;
    logic                       out_busy;
    logic                       hold;
    logic                       take_in;
    logic                       advance_prod;
    logic [DEG_W-1:0]           slot;
    logic                       slot_bad;
    logic [DEG_W-1:0]           deg_in;

    assign uw = ucode(r_step);

    // Effective row length: zero acts as one, clip at the maximum
    always_comb begin
        if (r_var_count == '0) begin
            count_eff = CNT_W'(1);
        end else if (r_var_count > CNT_W'(MAX_VARS)) begin
            count_eff = CNT_W'(MAX_VARS);
        end else begin
            count_eff = r_var_count;
        end
    end

    assign row_end  = ({1'b0, r_idx} + CNT_W'(1)) >= count_eff;
    assign out_busy = r_out_valid && !o_result.ready;

    // Hold the step while waiting on either side
    assign hold = ((uw.cond == C_WAIT_IN) && !i_sample.valid) ||
                  ((uw.cond == C_WAIT_OUT) && row_end && out_busy);

    assign i_sample.ready = (uw.cond == C_WAIT_IN);
    assign take_in        = i_sample.valid && i_sample.ready;
    assign advance_prod   = (uw.wb == WB_PROD) && !hold;

    // Degree slot of the current variable; out-of-range slots act as degree zero
    assign slot     = r_degree_word[{r_idx, 2'b00} +: DEG_W];
    assign slot_bad = slot > DEG_W'(MAX_DEG);
    assign deg_in   = slot_bad ? '0 : slot;

    assign dp_ctrl.msel    = uw.msel;
    assign dp_ctrl.wb      = hold ? WB_NONE : uw.wb;
    assign dp_ctrl.row_end = row_end;

    lmp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (dp_ctrl),
        .i_sample    (i_sample.sample),
        .i_deg       (deg_in),
        .o_stat      (dp_stat),
        .o_prod_next (prod_next)
    );

    // Next step of the microprogram
    always_comb begin
        n_step = r_step + STEP_W'(1);
        unique case (uw.cond)
            C_NEXT:       n_step = r_step + STEP_W'(1);
            C_JUMP:       n_step = uw.target;
            C_WAIT_IN:    n_step = hold ? r_step : r_step + STEP_W'(1);
            C_TERMS_DONE: n_step = dp_stat.terms_done ? uw.target : r_step + STEP_W'(1);
            C_EVEN:       n_step = !dp_stat.deg_odd ? uw.target : r_step + STEP_W'(1);
            C_WAIT_OUT:   n_step = hold ? r_step : uw.target;
            default:      n_step = UA_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= UA_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    // Configuration writes; an unused index is dropped by the decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_count   <= CNT_W'(1);
            r_degree_word <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VAR_COUNT:   r_var_count   <= i_cfg_data[CNT_W-1:0];
                REG_DEGREE_WORD: r_degree_word <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Row bookkeeping: advance the index, collect the bad-degree flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_err <= 1'b0;
        end else if (advance_prod) begin
            if (row_end) begin
                r_idx <= '0;
                r_err <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end else if (take_in && slot_bad) begin
            r_err <= 1'b1;
        end
    end

    // Output register: load at row end, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance_prod && row_end) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance_prod && row_end) begin
            r_out_product <= prod_next;
            r_out_bad     <= r_err;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.product    = r_out_product;
    assign o_result.bad_degree = r_out_bad;

endmodule

/* bench/tb_legendre_monomial_product_core.sv */
// Self-checking testbench of the Legendre monomial product core.
`timescale 1ns / 100ps

module tb_legendre_monomial_product_core import lmp_pkg::*;;

    localparam int     ITEM_TARGET   = 1250;
    localparam int     SETTLE_CYCLES = 40;      // covers the longest item plus the output
    localparam int     HOLD_CYCLES   = 400;
    localparam int     CYCLE_LIMIT   = 600000;
    localparam longint UNIT          = longint'(1) <<< FRAC_BITS;
    localparam longint HALF_UNIT     = UNIT / 2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] product;
        logic                       bad_degree;
    } t_row_result;

    // Expectation typed into the directed table, or none
    typedef struct packed {
        logic        pinned;
        t_row_result value;
    } t_pin;

    typedef enum logic [1:0] {
        PLAN_WRITE,
        PLAN_SAMPLE,
        PLAN_PINNED
    } t_plan_kind;

    typedef struct {
        t_plan_kind                 kind;
        t_reg_idx                   idx;
        logic [CFG_W-1:0]           data;
        logic signed [SAMPLE_W-1:0] sample;
        t_row_result                want;
    } t_plan_step;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    t_reg_idx         cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    lmp_sample_if smp ();
    lmp_result_if res ();

    legendre_monomial_product_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp),
        .o_result   (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Own copy of the registers and of the row state, at their reset values
    logic [CNT_W-1:0] row_length_reg = 5'd1;
    logic [CFG_W-1:0] degree_reg     = '0;
    longint           row_product    = UNIT;
    int               var_pos        = 0;
    bit               bad_seen       = 1'b0;

    t_row_result row_products_due [$];
    t_pin        pinned_rows [$];
    t_plan_step  plan [$];

    int failures     = 0;
    int cycle_count  = 0;
    int holds_asked  = 0;
    int holds_done   = 0;
    bit steady       = 1'b0;

    //------------------------------------------------------------------
    // Fixed-point arithmetic of the block
    //------------------------------------------------------------------

    // Multiply two fixed-point values, rounding half up
    function automatic longint qmul(input longint a, input longint b);
        return (a * b + HALF_UNIT) >>> FRAC_BITS;
    endfunction

    function automatic longint sat_one(input longint v);
        if (v > UNIT) begin
            return UNIT;
        end
        if (v < -UNIT) begin
            return -UNIT;
        end
        return v;
    endfunction

    // P_deg(x) for degree 1..10: Horner in x squared over integer numerators,
    // then one more factor x for odd degrees, then the power-of-two divide
    function automatic longint legendre_value(input int deg, input longint x);
        longint c [6];
        longint y;
        longint acc;
        int     sh;
        case (deg)
            1: begin c = '{1, 0, 0, 0, 0, 0};                           sh = 0; end
            2: begin c = '{3, -1, 0, 0, 0, 0};                          sh = 1; end
            3: begin c = '{5, -3, 0, 0, 0, 0};                          sh = 1; end
            4: begin c = '{35, -30, 3, 0, 0, 0};                        sh = 3; end
            5: begin c = '{63, -70, 15, 0, 0, 0};                       sh = 3; end
            6: begin c = '{231, -315, 105, -5, 0, 0};                   sh = 4; end
            7: begin c = '{429, -693, 315, -35, 0, 0};                  sh = 4; end
            8: begin c = '{6435, -12012, 6930, -1260, 35, 0};           sh = 7; end
            9: begin c = '{12155, -25740, 18018, -4620, 315, 0};        sh = 7; end
            default: begin c = '{46189, -109395, 90090, -30030, 3465, -63}; sh = 8; end
        endcase
        y   = qmul(x, x);
        acc = c[0] * UNIT;
        for (int i = 1; i < deg / 2 + 1; i++) begin
            acc = qmul(acc, y) + c[i] * UNIT;
        end
        if (deg % 2 == 1) begin
            acc = qmul(acc, x);
        end
        if (sh > 0) begin
            acc = (acc + (longint'(1) <<< (sh - 1))) >>> sh;
        end
        return sat_one(acc);
    endfunction

    function automatic void apply_register(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        case (idx)
            REG_VAR_COUNT:   row_length_reg = data[CNT_W-1:0];
            REG_DEGREE_WORD: degree_reg     = data;
            default: ;
        endcase
    endfunction

    // Fold one variable into the row; return 1 with the row's result when it ends
    function automatic bit absorb_variable(input logic signed [SAMPLE_W-1:0] s,
                                           output t_row_result r);
        longint           x;
        longint           leg;
        int               count;
        logic [DEG_W-1:0] deg;
        x     = sat_one(longint'(s));
        count = int'(row_length_reg);
        if (count == 0) begin
            count = 1;
        end
        if (count > MAX_VARS) begin
            count = MAX_VARS;
        end
        deg = degree_reg[DEG_W*var_pos +: DEG_W];
        // a slot above ten counts as degree zero and marks the row
        if (deg > MAX_DEG) begin
            bad_seen = 1'b1;
            deg      = '0;
        end
        leg         = (deg == 0) ? UNIT : legendre_value(int'(deg), x);
        row_product = sat_one(qmul(row_product, leg));
        var_pos++;
        r = '0;
        if (var_pos < count) begin
            return 1'b0;
        end
        r.product    = row_product[SAMPLE_W-1:0];
        r.bad_degree = bad_seen;
        row_product  = UNIT;
        var_pos      = 0;
        bad_seen     = 1'b0;
        return 1'b1;
    endfunction

    //------------------------------------------------------------------
    // Random stimulus
    //------------------------------------------------------------------

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        int          r;
        logic [31:0] w;
        r = $urandom_range(0, 99);
        w = $urandom();
        if (r < 4) begin
            return ONE_Q;
        end
        if (r < 8) begin
            return -ONE_Q;
        end
        if (r < 10) begin
            return '0;
        end
        // any 18-bit pattern, beyond one included
        if (r < 22) begin
            return w[SAMPLE_W-1:0];
        end
        w = $urandom_range(0, 2 * 65536) - 65536;
        return w[SAMPLE_W-1:0];
    endfunction

    // Mostly short rows so results keep coming; the out-of-range counts now and then
    function automatic logic [CNT_W-1:0] draw_row_length();
        int               r;
        logic [CNT_W-1:0] n;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            n = CNT_W'($urandom_range(0, 31));
        end else if (r < 18) begin
            n = 5'd1;
        end else if (r < 26) begin
            n = 5'd16;
        end else begin
            n = CNT_W'($urandom_range(1, 8));
        end
        return n;
    endfunction

    function automatic logic [CFG_W-1:0] draw_degree_word();
        int               r;
        logic [CFG_W-1:0] w;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '1;
        end
        if (r < 10) begin
            return '0;
        end
        if (r < 18) begin
            return {16{4'd10}};
        end
        for (int k = 0; k < MAX_VARS; k++) begin
            if ($urandom_range(0, 99) < 12) begin
                w[DEG_W*k +: DEG_W] = DEG_W'($urandom_range(11, 15));
            end else begin
                w[DEG_W*k +: DEG_W] = DEG_W'($urandom_range(0, 10));
            end
        end
        return w;
    endfunction

    //------------------------------------------------------------------
    // Directed table
    //------------------------------------------------------------------

    function automatic void add_write(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        t_plan_step p;
        p      = '{PLAN_WRITE, idx, data, '0, '0};
        plan.push_back(p);
    endfunction

    function automatic void add_sample(input logic signed [SAMPLE_W-1:0] s);
        t_plan_step p;
        p = '{PLAN_SAMPLE, REG_VAR_COUNT, '0, s, '0};
        plan.push_back(p);
    endfunction

    function automatic void add_pinned(input logic signed [SAMPLE_W-1:0] s,
                                       input logic signed [SAMPLE_W-1:0] product,
                                       input logic bad);
        t_plan_step p;
        p = '{PLAN_PINNED, REG_VAR_COUNT, '0, s, '{product, bad}};
        plan.push_back(p);
    endfunction

    //------------------------------------------------------------------
    // Drivers: everything changes on the falling edge
    //------------------------------------------------------------------

    // Offer one sample; return at the falling edge after its transfer
    task automatic offer(input logic signed [SAMPLE_W-1:0] s, input t_pin pin);
        pinned_rows.push_back(pin);
        while (!steady && $urandom_range(0, 99) < 8) begin
            smp.valid = 1'b0;
            @(negedge i_clk);
        end
        smp.valid  = 1'b1;
        smp.sample = s;
        do @(posedge i_clk); while (!smp.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    // Drain every due result, then let a row item still in flight finish
    task automatic settle_block();
        smp.valid = 1'b0;
        while (row_products_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Cycle guard: a hang anywhere ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random stalls, a long hold-off on request, none while steady
    initial begin
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                res.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_done++;
            end else begin
                res.ready = steady || ($urandom_range(0, 99) >= 8);
            end
        end
    end

    //------------------------------------------------------------------
    // Monitor: track register writes, predict on each sample transfer,
    // check each result transfer against the oldest due row
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_row_result row;
        t_row_result want;
        t_pin        pin;
        if (i_rst_n) begin
            if (cfg_we) begin
                apply_register(cfg_idx, cfg_data);
            end
            if (smp.valid && smp.ready) begin
                pin = '0;
                if (pinned_rows.size() != 0) begin
                    pin = pinned_rows.pop_front();
                end
                if (absorb_variable(smp.sample, row)) begin
                    row_products_due.push_back(pin.pinned ? pin.value : row);
                end
            end
            if (res.valid && res.ready) begin
                if (row_products_due.size() == 0) begin
                    $display("%0t: result with none due, expected nothing, actual %0d/%0b",
                             $time, $signed(res.product), res.bad_degree);
                    failures++;
                end else begin
                    want = row_products_due.pop_front();
                    if (res.product !== want.product) begin
                        $display("%0t: product mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.product), $signed(res.product));
                        failures++;
                    end
                    if (res.bad_degree !== want.bad_degree) begin
                        $display("%0t: bad_degree mismatch, expected %0b, actual %0b",
                                 $time, want.bad_degree, res.bad_degree);
                        failures++;
                    end
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial begin
        int               sent;
        int               phase;
        int               n;
        logic [CFG_W-1:0] word;
        t_pin             pin;

        i_rst_n    = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = REG_VAR_COUNT;
        cfg_data   = '0;
        smp.valid  = 1'b0;
        smp.sample = '0;
        sent       = 0;
        phase      = 0;

        // Hold reset, then release it on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // After reset: one variable of degree zero, so every sample gives 1.0
        add_pinned(ONE_Q, ONE_Q, 1'b0);
        add_pinned(-18'sd131072, ONE_Q, 1'b0);
        add_pinned(18'sd131071, ONE_Q, 1'b0);

        // Degree one: the row is the sample itself, clamped beyond one
        add_write(REG_DEGREE_WORD, 64'h1);
        add_pinned(18'sd131071, ONE_Q, 1'b0);
        add_pinned(-18'sd131072, -ONE_Q, 1'b0);
        add_pinned(18'sd1, 18'sd1, 1'b0);
        add_pinned(-18'sd1, -18'sd1, 1'b0);

        // Three variables: degree ten at one gives one, then two bad slots
        add_write(REG_VAR_COUNT, 64'd3);
        add_write(REG_DEGREE_WORD, 64'hFBA);
        add_sample(ONE_Q);
        add_sample(-18'sd20000);
        add_pinned(18'sd777, ONE_Q, 1'b1);

        // Count zero acts as one; degree nine is -1 at -1 and 0 at 0
        add_write(REG_VAR_COUNT, 64'd0);
        add_write(REG_DEGREE_WORD, 64'h9);
        add_pinned(-ONE_Q, -ONE_Q, 1'b0);
        add_pinned(18'sd0, 18'sd0, 1'b0);

        // Shorten the row part-way: it ends on the next sample
        add_write(REG_VAR_COUNT, 64'd3);
        add_write(REG_DEGREE_WORD, 64'h222);
        add_sample(18'sd30000);
        add_sample(-18'sd40000);
        add_write(REG_VAR_COUNT, 64'd2);
        add_sample(18'sd12345);

        @(negedge i_clk);
        for (int i = 0; i < plan.size(); i++) begin
            if (plan[i].kind == PLAN_WRITE) begin
                settle_block();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                pin = '{plan[i].kind == PLAN_PINNED, plan[i].want};
                offer(plan[i].sample, pin);
            end
        end

        // Random phases: reprogram while idle, then a burst of samples.
        // Phase two asks for the long receiver hold-off with one-variable
        // rows so the output fills and the input stalls; phases six to
        // nine run without any idling on either side.
        while (sent < ITEM_TARGET) begin
            settle_block();
            steady = (phase >= 6 && phase <= 9);
            word   = {$urandom(), $urandom()};
            word[CNT_W-1:0] = (phase == 2) ? 5'd1 : draw_row_length();
            write_reg(REG_VAR_COUNT, word);
            write_reg(REG_DEGREE_WORD, draw_degree_word());
            if (phase == 2) begin
                holds_asked++;
            end
            n = $urandom_range(20, 60);
            repeat (n) begin
                offer(draw_sample(), '0);
                sent++;
            end
            phase++;
        end

        steady = 1'b0;
        settle_block();
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
